// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files. They sample on clk_i and
// are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define SWTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define SWTM_NEVER(lbl, cond, msg) \
  `SWTM_ASSERT(lbl, !(cond), msg)

`endif

// ===== hdl/swtm_pkg.sv =====
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared constants, register indexes and sequencer states of the
// sliding-window trimmed mean filter.
// ----------------------------------------------------------------------------
package swtm_pkg;

  // parameter defaults
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration register layout
  localparam int WS_W       = 7;
  localparam int TRIM_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT  = 2'd1;

  localparam logic [WS_W-1:0]   WINDOW_RST = 7'd3;
  localparam logic [TRIM_W-1:0] TRIM_RST   = 5'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REM_RD,
    ST_REM,
    ST_INS_RD,
    ST_INS,
    ST_SUM_RD,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== hdl/swtm_div.sv =====
// ----------------------------------------------------------------------------
// swtm_div
// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module swtm_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ITER_W'(1);
        if (cnt_q == ITER_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/sliding_window_trimmed_mean.sv =====
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean
// Trimmed mean over the last window_size samples of an unsigned stream.
//   s_axis: one sample per request in tdata. m_axis: one result per sample,
//   trimmed_mean in tdata, mean_valid in tuser. The result is flagged
//   invalid until the window has filled or while 2*trim_count >= window.
//   cfg: write port, index 0 window_size (flushes the window), index 1
//   trim_count. Write only while the block is idle.
//   Rate: one sample at a time. s_axis_tready is high only while idle.
//   A sample's work is a sweep over the sorted store: evict the oldest
//   sample once the window is full, insert the new one by shifting, and,
//   when the result is valid, sum the kept entries and run the
//   one-bit-per-cycle divider.
//   Window size zero gives an invalid result.
//   The result sits in an output register; a stalled receiver holds it
//   there and the block takes the next sample meanwhile, waiting only when
//   a second result is ready before the first is taken.
//   Reset: window 3, trim 1, window empty. Memories are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_trimmed_mean #(
  parameter int MAX_WINDOW  = swtm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF,
  parameter int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [swtm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swtm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // [0 +: SAMPLE_BITS] sample
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata,  // [0 +: SAMPLE_BITS] trimmed_mean
  output logic                            m_axis_tuser   // [0] mean_valid
);

  import swtm_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int CW    = (CNT_W > WS_W) ? CNT_W : WS_W;

  // --- storage ---
  logic [SAMPLE_BITS-1:0] ring_mem   [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] sorted_mem [MAX_WINDOW];

  // --- registers ---
  state_e                 state_q, state_d;
  logic [WS_W-1:0]        ws_q, ws_d;
  logic [TRIM_W-1:0]      trim_q, trim_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   found_q, found_d;
  logic [SUM_W-1:0]       acc_q, acc_d;
  logic                   res_flag_q, res_flag_d;
  logic                   m_valid_q, m_valid_d;
  logic [SAMPLE_BITS-1:0] v_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] rda_q, rdb_q;
  logic [TDATA_W-1:0]     m_data_q;
  logic                   m_user_q;

  // --- combinational ---
  logic                   accept;
  logic                   out_load;
  logic [CNT_W-1:0]       w;
  logic [CW-1:0]          ws_cw, w_cw, t_cw, t2_cw;
  logic                   trim_ok;
  logic [CNT_W-1:0]       mid_cnt;
  logic [CW-1:0]          last_idx;
  logic [IDX_W-1:0]       ra, rb;
  logic                   s_we;
  logic [IDX_W-1:0]       s_wa;
  logic [SAMPLE_BITS-1:0] s_wd;
  logic                   ring_we;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quot;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // effective window and trim limits
  assign ws_cw    = CW'(ws_q);
  assign w_cw     = (ws_cw > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : ws_cw;
  assign w        = CNT_W'(w_cw);
  assign t_cw     = CW'(trim_q);
  assign t2_cw    = CW'({trim_q, 1'b0});
  assign trim_ok  = t2_cw < w_cw;
  assign mid_cnt  = CNT_W'(w_cw - t2_cw);
  assign last_idx = w_cw - t_cw - CW'(1);

  // --- sequencer ---
  always_comb begin
    state_d    = state_q;
    ws_d       = ws_q;
    trim_d     = trim_q;
    fill_d     = fill_q;
    head_d     = head_q;
    idx_d      = idx_q;
    found_d    = found_q;
    acc_d      = acc_q;
    res_flag_d = res_flag_q;
    m_valid_d  = m_valid_q;
    out_load   = 1'b0;
    ra         = '0;
    rb         = '0;
    s_we       = 1'b0;
    s_wa       = idx_q;
    s_wd       = v_q;
    ring_we    = 1'b0;
    div_start  = 1'b0;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (w == '0) begin
            res_flag_d = 1'b0;
            state_d    = ST_OUT;
          end else begin
            ring_we = 1'b1;
            head_d  = (CW'(head_q) + CW'(1) >= w_cw) ? '0 : head_q + IDX_W'(1);
            if (fill_q == w) begin
              if (CW'(fill_q) >= CW'(2)) begin
                state_d = ST_REM_RD;
              end else begin
                // single-entry window: eviction empties it
                fill_d  = '0;
                idx_d   = '0;
                state_d = ST_INS;
              end
            end else begin
              idx_d   = IDX_W'(fill_q);
              state_d = (fill_q == '0) ? ST_INS : ST_INS_RD;
            end
          end
        end
      end
      ST_REM_RD: begin
        ra      = '0;
        rb      = IDX_W'(1);
        idx_d   = '0;
        found_d = 1'b0;
        state_d = ST_REM;
      end
      ST_REM: begin
        // close the gap left by the oldest sample
        ra      = idx_q + IDX_W'(1);
        rb      = idx_q + IDX_W'(2);
        found_d = found_q || (rda_q == old_q);
        if (found_d) begin
          s_we = 1'b1;
          s_wa = idx_q;
          s_wd = rdb_q;
        end
        if (CW'(idx_q) == CW'(fill_q) - CW'(2)) begin
          fill_d  = fill_q - CNT_W'(1);
          idx_d   = IDX_W'(fill_d);
          state_d = ST_INS_RD;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_INS_RD: begin
        ra      = idx_q - IDX_W'(1);
        state_d = ST_INS;
      end
      ST_INS: begin
        // rda_q holds entry idx-1; shift it up while above the new sample
        ra   = idx_q - IDX_W'(2);
        s_we = 1'b1;
        s_wa = idx_q;
        if (idx_q == '0 || rda_q <= v_q) begin
          s_wd   = v_q;
          fill_d = fill_q + CNT_W'(1);
          if (fill_d == w && trim_ok) begin
            state_d = ST_SUM_RD;
          end else begin
            res_flag_d = 1'b0;
            state_d    = ST_OUT;
          end
        end else begin
          s_wd  = rda_q;
          idx_d = idx_q - IDX_W'(1);
        end
      end
      ST_SUM_RD: begin
        ra      = IDX_W'(trim_q);
        idx_d   = IDX_W'(trim_q);
        acc_d   = '0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        ra    = idx_q + IDX_W'(1);
        acc_d = acc_q + SUM_W'(rda_q);
        if (CW'(idx_q) == last_idx) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_flag_d = 1'b1;
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // the user must write config only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_WINDOW_SIZE) begin
        ws_d   = cfg_data_i[WS_W-1:0];
        fill_d = '0;
        head_d = '0;
      end else if (cfg_idx_i == REG_TRIM_COUNT) begin
        trim_d = cfg_data_i[TRIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ws_q       <= WINDOW_RST;
      trim_q     <= TRIM_RST;
      fill_q     <= '0;
      head_q     <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      res_flag_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ws_q       <= ws_d;
      trim_q     <= trim_d;
      fill_q     <= fill_d;
      head_q     <= head_d;
      idx_q      <= idx_d;
      found_q    <= found_d;
      res_flag_q <= res_flag_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (accept) v_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    if (out_load) begin
      m_user_q <= res_flag_q;
      m_data_q <= res_flag_q ? TDATA_W'(div_quot[SAMPLE_BITS-1:0]) : '0;
    end
  end

  // arrival ring: oldest sample read out as the new one overwrites it
  always_ff @(posedge clk_i) begin
    if (accept) old_q <= ring_mem[head_q];
    if (ring_we) ring_mem[head_q] <= s_axis_tdata[SAMPLE_BITS-1:0];
  end

  // sorted copy: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (s_we) sorted_mem[s_wa] <= s_wd;
    rda_q <= sorted_mem[ra];
    rdb_q <= sorted_mem[rb];
  end

  swtm_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d),
    .divisor_i  (mid_cnt),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `SWTM_ASSERT(a_fill_bound, CW'(fill_q) <= w_cw, "fill count exceeds window")
  `SWTM_ASSERT(a_accept_busy, accept |=> state_q != ST_IDLE, "sample accepted without work")
  `SWTM_NEVER(a_ins_range, (state_q == ST_INS) && (CNT_W'(idx_q) > fill_q),
              "insert slot beyond fill count")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window trimmed mean filter.
//   A queue of samples feeds a clocked stream driver. Each accepted request
//   runs through a bench-side window model, which keeps its own arrival
//   ring and sorted copy. The model's result is queued, and a clocked
//   monitor checks it field by field against what m_axis delivers.
//   The directed corners come first: sample extremes, zero and oversized
//   windows, zero and oversized trims, and ignored register indexes. Random
//   segments follow under three pacing profiles on the sample and result
//   sides.
// ----------------------------------------------------------------------------
module tb_top;
  import swtm_pkg::*;

  localparam int WIN_MAX = MAX_WINDOW_DEF;
  localparam int SMP_W   = SAMPLE_BITS_DEF;
  localparam int TD_W    = ((SMP_W + 7) / 8) * 8;

  // indexes with no register behind them; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // long enough for the slowest sample (W=64), so this covers a straggler
  localparam int DRAIN_CYCLES = 250;

  typedef logic [SMP_W-1:0] sample_t;
  typedef struct packed {
    logic    mean_valid;
    sample_t trimmed_mean;
  } mean_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TD_W-1:0]       s_axis_tdata  = '0;  // [0 +: SMP_W] sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TD_W-1:0]       m_axis_tdata;        // [0 +: SMP_W] trimmed_mean
  logic                  m_axis_tuser;        // [0] mean_valid

  sliding_window_trimmed_mean i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  sample_t      samples_to_send [$];   // filled by the stimulus block
  mean_result_t expected_means  [$];   // one per accepted request, in order

  int unsigned send_idle_pct = 31;     // chance per cycle the sender holds off
  int unsigned recv_idle_pct = 50;     // chance per cycle the receiver stalls

  int unsigned error_count      = 0;
  int unsigned samples_accepted = 0;
  int unsigned results_checked  = 0;
  int unsigned valid_results    = 0;
  int unsigned regs_written     = 0;

  // window model: configuration plus both copies of the window
  logic [WS_W-1:0]   win_size_m;
  logic [TRIM_W-1:0] trim_m;
  sample_t           arrival_m [WIN_MAX];
  sample_t           sorted_m  [WIN_MAX];
  int unsigned       head_m;   // ring slot of the oldest sample
  int unsigned       held_m;   // samples held, never more than the window

  // Push one sample through the window model and return the result it
  // should produce. Oldest sample out first (once full), then sorted insert.
  function automatic mean_result_t next_trimmed_mean(sample_t smp);
    int unsigned  w;
    int unsigned  t;
    int unsigned  pos;
    int unsigned  i;
    logic [31:0]  sum;
    mean_result_t res;
    res = '0;
    w   = (win_size_m > WIN_MAX) ? WIN_MAX : win_size_m;  // oversized clamps
    t   = trim_m;
    if (w == 0) return res;   // zero window: sample dropped, result invalid
    if (head_m >= w) head_m = 0;
    if (held_m >= w) begin
      // evict the first sorted entry equal to the oldest arrival
      pos = held_m;
      for (i = 0; i < held_m; i++) begin
        if (sorted_m[i] == arrival_m[head_m]) begin
          pos = i;
          break;
        end
      end
      if (pos < held_m) begin
        for (i = pos; i + 1 < held_m; i++) sorted_m[i] = sorted_m[i + 1];
        held_m--;
      end
      if (held_m > w - 1) held_m = w - 1;
    end
    i = held_m;
    while (i > 0 && sorted_m[i - 1] > smp) begin
      sorted_m[i] = sorted_m[i - 1];
      i--;
    end
    sorted_m[i] = smp;
    held_m++;
    arrival_m[head_m] = smp;
    head_m = (head_m + 1 >= w) ? 0 : head_m + 1;
    // valid only with a full window and a trim that leaves something
    if (held_m == w && 2 * t < w) begin
      sum = '0;
      for (i = t; i < w - t; i++) sum += sorted_m[i];
      res.mean_valid   = 1'b1;
      res.trimmed_mean = sample_t'(sum / (w - 2 * t));
    end
    return res;
  endfunction

  // Mix of repeats, values next to the extremes and full-range values.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 3))
      0:       return sample_t'($urandom_range(0, 7));
      1:       return sample_t'((2 ** SMP_W) - 1 - $urandom_range(0, 3));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // sample driver: takes requests from the queue, holds tvalid until the
  // handshake, and predicts the result of every accepted request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_means.insert(expected_means.size(),
                              next_trimmed_mean(s_axis_tdata[SMP_W-1:0]));
        samples_accepted++;
      end
      // the slot is free after this edge unless a request is still waiting
      if (!s_axis_tvalid || s_axis_tready) begin
        if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TD_W'(samples_to_send[0]);
          samples_to_send.delete(0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: random back-pressure, in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    mean_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: result with no request pending: mean_valid %0d trimmed_mean %0d",
                   $time, m_axis_tuser, m_axis_tdata[SMP_W-1:0]);
          error_count++;
        end else begin
          want = expected_means[0];
          expected_means.delete(0);
          results_checked++;
          if (want.mean_valid) valid_results++;
          if (m_axis_tuser !== want.mean_valid) begin
            $display("%0t: mean_valid mismatch: expected %0d actual %0d",
                     $time, want.mean_valid, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata[SMP_W-1:0] !== want.trimmed_mean) begin
            $display("%0t: trimmed_mean mismatch: expected %0d actual %0d",
                     $time, want.trimmed_mean, m_axis_tdata[SMP_W-1:0]);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // Register write, mirrored into the model. Only called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_WINDOW_SIZE: begin
        // any window write flushes the window
        win_size_m = val[WS_W-1:0];
        head_m     = 0;
        held_m     = 0;
      end
      REG_TRIM_COUNT: trim_m = val[TRIM_W-1:0];  // samples held are kept
      default: ;
    endcase
    regs_written++;
  endtask

  // Append one sample to the send queue.
  task automatic add_sample(sample_t smp);
    samples_to_send.insert(samples_to_send.size(), smp);
  endtask

  task automatic queue_samples(int unsigned n);
    repeat (n) add_sample(rand_sample());
  endtask

  // Block is idle once every request is sent and every result is back;
  // each sample yields exactly one result, so nothing is left in flight.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || s_axis_tvalid || expected_means.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sample_t     corner_vals [7];
    int unsigned mode;
    int unsigned budget;
    int unsigned n;
    int unsigned part;
    int unsigned ws;
    int unsigned weff;
    int unsigned tc;
    bit          lead;

    // model matches the reset state: window 3, trim 1, empty
    win_size_m = WINDOW_RST;
    trim_m     = TRIM_RST;
    head_m     = 0;
    held_m     = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed corners, reset config (W=3, trim 1) ----
    // first two results are invalid while the window fills
    corner_vals = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 16'h0000};
    foreach (corner_vals[k]) add_sample(corner_vals[k]);
    wait_drained();

    // zero trim: plain mean over the window, samples kept
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(0));
    add_sample(16'd1);
    add_sample(16'd2);
    wait_drained();

    // trim too large for the window: invalid, samples still stored
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(2));
    add_sample(16'd3);
    add_sample(16'd4);
    wait_drained();

    // writes to unused indexes must not touch window or trim
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(1));
    write_reg(REG_SPARE_A, CFG_DATA_W'(7'h7F));
    write_reg(REG_SPARE_B, CFG_DATA_W'(0));
    add_sample(16'd5);
    wait_drained();

    // zero window: every result invalid
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(0));
    add_sample(16'd6);
    add_sample(16'hFFFF);
    wait_drained();

    // new window length flushes, then refills
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(4));
    foreach (corner_vals[k]) corner_vals[k] = '0;
    add_sample(16'd100);
    add_sample(16'd200);
    add_sample(16'd300);
    add_sample(16'hFFFF);
    add_sample(16'd7);
    wait_drained();

    // oversized window clamps to the maximum; largest trim
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(127));
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(31));
    add_sample(16'd9);
    add_sample(16'd8);
    wait_drained();

    // ---- random segments under three pacing profiles ----
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 31; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      budget = 225;
      lead   = 1'b1;
      while (budget > 0) begin
        // each profile opens with one extreme setting
        if (lead) begin
          ws = (mode == 0) ? 64 : (mode == 1) ? 127 : 3;
        end else begin
          case ($urandom_range(0, 15))
            0:       ws = 0;
            1:       ws = 64;
            2:       ws = $urandom_range(65, 127);
            default: ws = $urandom_range(3, 16);
          endcase
        end
        weff = (ws > WIN_MAX) ? WIN_MAX : ws;
        if (lead) begin
          tc = (mode == 0) ? 31 : (mode == 1) ? 0 : 1;
        end else if (weff == 0 || $urandom_range(0, 4) == 0) begin
          tc = $urandom_range(0, 31);   // often too large: invalid results
        end else begin
          tc = $urandom_range(0, (weff - 1) / 2);
        end
        write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(ws));
        write_reg(REG_TRIM_COUNT, CFG_DATA_W'(tc));

        // fill the window and run a bit, then maybe retrim with samples held
        n    = (weff == 0) ? 8 : weff + $urandom_range(4, 30);
        part = weff + (n - weff) / 2;
        queue_samples(part);
        wait_drained();
        if (weff != 0 && $urandom_range(0, 1) != 0)
          write_reg(REG_TRIM_COUNT, CFG_DATA_W'($urandom_range(0, (weff - 1) / 2)));
        queue_samples(n - part);
        wait_drained();

        budget = (budget > n) ? budget - n : 0;
        lead   = 1'b0;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d results (%0d valid) from %0d samples", results_checked,
             valid_results, samples_accepted);
    $display("%0d register writes: windows 0..127, trims 0..31, unused indexes, 3 pacings",
             regs_written);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // watchdog: far beyond the slowest legal run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_means.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
